[hw/rtl/rre_pkg.sv]
// ----------------------------------------------------------------------------
// rre_pkg
// shared constants, codes and controller/datapath interface types for the
// rectangle raster engine
// ----------------------------------------------------------------------------
package rre_pkg;

   localparam int MAX_WIDTH  = 64;
   localparam int MAX_HEIGHT = 64;
   localparam int FB_DEPTH   = MAX_WIDTH * MAX_HEIGHT;
   localparam int ADDR_W     = $clog2(FB_DEPTH);
   localparam int X_W        = $clog2(MAX_WIDTH + 1);
   localparam int Y_W        = $clog2(MAX_HEIGHT + 1);

   localparam int PIX_W   = 32;
   localparam int COORD_W = 13;
   localparam int SUM_W   = COORD_W + 1;
   localparam int CFG_W   = 7;
   localparam int FUNC_W  = 2;

   localparam logic [CFG_W-1:0] FB_WIDTH_RESET  = 7'd64;
   localparam logic [CFG_W-1:0] FB_HEIGHT_RESET = 7'd64;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_PLOT    = 2'd0,
      FUNC_FILL    = 2'd1,
      FUNC_OUTLINE = 2'd2,
      FUNC_READ    = 2'd3
   } func_type;

   typedef enum logic {
      CSR_FB_WIDTH  = 1'b0,
      CSR_FB_HEIGHT = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic clear_en;
      logic load_req;
      logic setup;
      logic read_en;
      logic write_en;
      logic step;
      logic capture;
      logic load_rsp;
   } dp_cmd_type;

   typedef struct packed {
      logic clear_last;
      logic empty;
      logic is_read;
      logic on_path;
      logic last_pixel;
   } dp_status_type;

endpackage

[hw/rtl/rre_ram.sv]
// ----------------------------------------------------------------------------
// rre_ram
// generic simple dual port ram, one write port and one registered read port
// ----------------------------------------------------------------------------
module rre_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/rre_datapath.sv]
// ----------------------------------------------------------------------------
// rre_datapath
// configuration registers, request registers, clipping, pixel scan cursor,
// framebuffer with raster operation and response register
// ----------------------------------------------------------------------------
module rre_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   input  logic                                csr_index,
   input  logic        [rre_pkg::CFG_W-1:0]    csr_data,
   input  logic        [rre_pkg::FUNC_W-1:0]   req_func,
   input  logic signed [rre_pkg::COORD_W-1:0]  req_pos_x,
   input  logic signed [rre_pkg::COORD_W-1:0]  req_pos_y,
   input  logic signed [rre_pkg::COORD_W-1:0]  req_rect_w,
   input  logic signed [rre_pkg::COORD_W-1:0]  req_rect_h,
   input  logic        [rre_pkg::PIX_W-1:0]    req_keep_mask,
   input  logic        [rre_pkg::PIX_W-1:0]    req_paint_color,
   input  rre_pkg::dp_cmd_type                 cmd,
   output rre_pkg::dp_status_type              status,
   output logic        [rre_pkg::PIX_W-1:0]    rsp_pixel_value,
   output logic                                rsp_pixel_in_range
);

   import rre_pkg::*;

   logic [CFG_W-1:0]         fb_width_ff, fb_height_ff;
   logic [ADDR_W-1:0]        clear_cnt_ff;
   func_type                 func_ff;
   logic signed [COORD_W-1:0] pos_x_ff, pos_y_ff, rect_w_ff, rect_h_ff;
   logic [PIX_W-1:0]         keep_mask_ff, paint_color_ff;
   logic [X_W-1:0]           x_first_ff, x_last_ff, cur_x_ff, cur_x_in;
   logic [Y_W-1:0]           y_last_ff, cur_y_ff, cur_y_in;
   logic signed [SUM_W-1:0]  edge_left_ff, edge_right_ff, edge_top_ff, edge_bottom_ff;
   logic [PIX_W-1:0]         res_value_ff, rsp_value_ff;
   logic                     res_ok_ff, rsp_ok_ff;

   logic signed [SUM_W-1:0]  act_w, act_h, sx, sy, w_eff, h_eff;
   logic signed [SUM_W-1:0]  x_end, y_end, x_lo, y_lo, x_hi, y_hi, x_hi_m1, y_hi_m1;
   logic signed [SUM_W-1:0]  x_right, y_bottom, cur_xs, cur_ys;
   logic                     single, border;
   logic [X_W+Y_W-1:0]       lin_addr;
   logic [ADDR_W-1:0]        pix_addr, wr_addr;
   logic [PIX_W-1:0]         rd_data, wr_data;
   logic                     wr_en;

   // active size, clipped to the framebuffer limits
   always_comb begin
      act_w = $signed({{(SUM_W-CFG_W){1'b0}}, fb_width_ff});
      act_h = $signed({{(SUM_W-CFG_W){1'b0}}, fb_height_ff});
      if (act_w > SUM_W'(MAX_WIDTH)) begin
         act_w = SUM_W'(MAX_WIDTH);
      end
      if (act_h > SUM_W'(MAX_HEIGHT)) begin
         act_h = SUM_W'(MAX_HEIGHT);
      end
   end

   // rectangle clipping, plot and read act as a one pixel rectangle
   always_comb begin
      single   = (func_ff == FUNC_PLOT) || (func_ff == FUNC_READ);
      sx       = SUM_W'(pos_x_ff);
      sy       = SUM_W'(pos_y_ff);
      w_eff    = single ? SUM_W'(1) : SUM_W'(rect_w_ff);
      h_eff    = single ? SUM_W'(1) : SUM_W'(rect_h_ff);
      x_end    = sx + w_eff;
      y_end    = sy + h_eff;
      x_right  = x_end - SUM_W'(1);
      y_bottom = y_end - SUM_W'(1);
      x_lo     = sx[SUM_W-1] ? '0 : sx;
      y_lo     = sy[SUM_W-1] ? '0 : sy;
      x_hi     = (x_end > act_w) ? act_w : x_end;
      y_hi     = (y_end > act_h) ? act_h : y_end;
      x_hi_m1  = x_hi - SUM_W'(1);
      y_hi_m1  = y_hi - SUM_W'(1);
   end

   assign status.empty = w_eff[SUM_W-1] || (w_eff == '0) || h_eff[SUM_W-1] || (h_eff == '0)
                         || (x_lo >= x_hi) || (y_lo >= y_hi);

   // scan cursor and border test
   always_comb begin
      cur_xs = $signed({{(SUM_W-X_W){1'b0}}, cur_x_ff});
      cur_ys = $signed({{(SUM_W-Y_W){1'b0}}, cur_y_ff});
      border = (cur_xs == edge_left_ff) || (cur_xs == edge_right_ff)
               || (cur_ys == edge_top_ff) || (cur_ys == edge_bottom_ff);
      if (cur_x_ff == x_last_ff) begin
         cur_x_in = x_first_ff;
         cur_y_in = cur_y_ff + Y_W'(1);
      end else begin
         cur_x_in = cur_x_ff + X_W'(1);
         cur_y_in = cur_y_ff;
      end
   end

   assign status.is_read    = (func_ff == FUNC_READ);
   assign status.on_path    = (func_ff != FUNC_OUTLINE) || border;
   assign status.last_pixel = (cur_x_ff == x_last_ff) && (cur_y_ff == y_last_ff);
   assign status.clear_last = (clear_cnt_ff == ADDR_W'(FB_DEPTH - 1));

   // pixel address y * width + x
   assign lin_addr = (X_W+Y_W)'(cur_y_ff) * (X_W+Y_W)'(act_w[X_W-1:0])
                     + (X_W+Y_W)'(cur_x_ff);
   assign pix_addr = lin_addr[ADDR_W-1:0];

   assign wr_en   = cmd.clear_en || cmd.write_en;
   assign wr_addr = cmd.clear_en ? clear_cnt_ff : pix_addr;
   assign wr_data = cmd.clear_en ? '0 : ((rd_data & keep_mask_ff) | paint_color_ff);

   rre_ram #(
      .WIDTH (PIX_W),
      .DEPTH (FB_DEPTH)
   ) u_frame_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (cmd.read_en),
      .rd_addr (pix_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         fb_width_ff  <= FB_WIDTH_RESET;
         fb_height_ff <= FB_HEIGHT_RESET;
         clear_cnt_ff <= '0;
      end else begin
         if (csr_valid) begin
            unique case (csr_index_type'(csr_index))
               CSR_FB_WIDTH:  fb_width_ff  <= csr_data;
               CSR_FB_HEIGHT: fb_height_ff <= csr_data;
               default: ;
            endcase
         end
         if (cmd.clear_en) begin
            clear_cnt_ff <= clear_cnt_ff + ADDR_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         func_ff        <= func_type'(req_func);
         pos_x_ff       <= req_pos_x;
         pos_y_ff       <= req_pos_y;
         rect_w_ff      <= req_rect_w;
         rect_h_ff      <= req_rect_h;
         keep_mask_ff   <= req_keep_mask;
         paint_color_ff <= req_paint_color;
      end
      if (cmd.setup) begin
         x_first_ff     <= x_lo[X_W-1:0];
         cur_x_ff       <= x_lo[X_W-1:0];
         cur_y_ff       <= y_lo[Y_W-1:0];
         x_last_ff      <= x_hi_m1[X_W-1:0];
         y_last_ff      <= y_hi_m1[Y_W-1:0];
         edge_left_ff   <= sx;
         edge_right_ff  <= x_right;
         edge_top_ff    <= sy;
         edge_bottom_ff <= y_bottom;
         res_value_ff   <= '0;
         res_ok_ff      <= 1'b0;
      end else if (cmd.step) begin
         cur_x_ff <= cur_x_in;
         cur_y_ff <= cur_y_in;
      end
      if (cmd.capture) begin
         res_value_ff <= rd_data;
         res_ok_ff    <= 1'b1;
      end
      if (cmd.load_rsp) begin
         rsp_value_ff <= res_value_ff;
         rsp_ok_ff    <= res_ok_ff;
      end
   end

   assign rsp_pixel_value    = rsp_value_ff;
   assign rsp_pixel_in_range = rsp_ok_ff;

endmodule

[hw/rtl/rre_ctrl.sv]
// ----------------------------------------------------------------------------
// rre_ctrl
// sequencer for the clearing pass, request intake, pixel scan with
// read-modify-write and response hand-off
// ----------------------------------------------------------------------------
module rre_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  rre_pkg::dp_status_type status,
   output rre_pkg::dp_cmd_type    cmd
);

   import rre_pkg::*;

   typedef enum logic [6:0] {
      S_CLEAR  = 7'b0000001,
      S_IDLE   = 7'b0000010,
      S_SETUP  = 7'b0000100,
      S_VISIT  = 7'b0001000,
      S_MODIFY = 7'b0010000,
      S_FETCH  = 7'b0100000,
      S_RESP   = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clear_en = 1'b1;
            if (status.clear_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = S_SETUP;
            end
         end
         S_SETUP: begin
            cmd.setup = 1'b1;
            state_in  = status.empty ? S_RESP : S_VISIT;
         end
         S_VISIT: begin
            if (status.is_read) begin
               cmd.read_en = 1'b1;
               state_in    = S_FETCH;
            end else if (status.on_path) begin
               cmd.read_en = 1'b1;
               state_in    = S_MODIFY;
            end else begin
               cmd.step = 1'b1;
               state_in = status.last_pixel ? S_RESP : S_VISIT;
            end
         end
         S_MODIFY: begin
            cmd.write_en = 1'b1;
            cmd.step     = 1'b1;
            state_in     = status.last_pixel ? S_RESP : S_VISIT;
         end
         S_FETCH: begin
            cmd.capture = 1'b1;
            state_in    = S_RESP;
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_write_after_read: assert property (@(posedge clock) disable iff (reset)
      cmd.write_en |-> $past(cmd.read_en))
      else $error("pixel write without preceding read");

   a_clear_exclusive: assert property (@(posedge clock) disable iff (reset)
      cmd.clear_en |-> !(cmd.write_en || cmd.read_en || req_ready))
      else $error("framebuffer access during clearing pass");

   a_rsp_loaded: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |=> rsp_valid_ff)
      else $error("response loaded but not presented");

   a_setup_follows: assert property (@(posedge clock) disable iff (reset)
      cmd.load_req |=> cmd.setup)
      else $error("request taken without setup");

endmodule

[hw/rtl/rect_raster_engine_top.sv]
// ----------------------------------------------------------------------------
// rect_raster_engine_top
// rectangle fill and outline rasterizer over a 64 x 64 framebuffer of
// 32-bit pixels with mask-and-color raster operation
// ----------------------------------------------------------------------------
// usage:
//  - request channel req_*: plot, fill, outline or read; one response on
//    rsp_* for every request (pixel value and in-range flag for reads, zero
//    otherwise)
//  - csr_* writes fb_width (index 0) and fb_height (index 1); always ready,
//    to be written only while no request is in flight
//  - after reset the framebuffer is cleared one word a cycle, all 4096
//    words, with req_ready low, then the block takes requests
//  - one request at a time: accept, a setup state, then the scan of the
//    clipped rectangle (ram read, then write through the single write port
//    for each updated pixel; a skipped outline interior pixel is stepped
//    over without ram access); a read goes from its ram read to a fetch
//    state, an empty or out-of-range request from setup to the response
//    state; the next request can be taken in the cycle after the response
//    is loaded
//  - the response sits in an output register; a stalled receiver holds it,
//    and the next request is accepted and worked on meanwhile, its response
//    waiting until the register is free
// ----------------------------------------------------------------------------
module rect_raster_engine_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic                                csr_index,
   input  logic        [rre_pkg::CFG_W-1:0]    csr_data,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic        [rre_pkg::FUNC_W-1:0]   req_func,
   input  logic signed [rre_pkg::COORD_W-1:0]  req_pos_x,
   input  logic signed [rre_pkg::COORD_W-1:0]  req_pos_y,
   input  logic signed [rre_pkg::COORD_W-1:0]  req_rect_w,
   input  logic signed [rre_pkg::COORD_W-1:0]  req_rect_h,
   input  logic        [rre_pkg::PIX_W-1:0]    req_keep_mask,
   input  logic        [rre_pkg::PIX_W-1:0]    req_paint_color,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic        [rre_pkg::PIX_W-1:0]    rsp_pixel_value,
   output logic                                rsp_pixel_in_range
);

   import rre_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   assign csr_ready = 1'b1;

   rre_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   rre_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .csr_valid          (csr_valid),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .req_func           (req_func),
      .req_pos_x          (req_pos_x),
      .req_pos_y          (req_pos_y),
      .req_rect_w         (req_rect_w),
      .req_rect_h         (req_rect_h),
      .req_keep_mask      (req_keep_mask),
      .req_paint_color    (req_paint_color),
      .cmd                (cmd),
      .status             (status),
      .rsp_pixel_value    (rsp_pixel_value),
      .rsp_pixel_in_range (rsp_pixel_in_range)
   );

endmodule
